FILE: src/bmq_pkg.sv
// ----------------------------------------------------------------------------
// bmq_pkg: shared types and constants of the message queue pair
// Operation codes, field widths, sequencer states, the ram entry record and
// the request and result records passed between sequencer and top level.
// ----------------------------------------------------------------------------
package bmq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int CONN_W              = 16;
   localparam int SEQ_W               = 32;
   localparam int HANDLE_W            = 32;
   localparam int LIMIT_W             = 5;
   localparam int DRAIN_W             = 5;
   localparam int DROP_W              = 32;
   localparam int OP_W                = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd16;
   localparam logic [DRAIN_W-1:0] RESULT_BOUND = 5'd16;

   localparam logic [OP_W-1:0] OP_ENQ_OUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENQ_IN    = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN_OUT = 2'd2;
   localparam logic [OP_W-1:0] OP_DRAIN_IN  = 2'd3;

   localparam logic Q_OUT = 1'b0;
   localparam logic Q_IN  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [CONN_W-1:0]   dest;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [CONN_W-1:0]   dest_conn;
      logic [SEQ_W-1:0]    msg_seq_in;
      logic [HANDLE_W-1:0] msg_handle;
      logic [DRAIN_W-1:0]  drain_max;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic                has_msg;
      logic [CONN_W-1:0]   out_dest;
      logic [SEQ_W-1:0]    out_seq;
      logic [HANDLE_W-1:0] out_handle;
      logic                last_of_run;
      logic [DROP_W-1:0]   drop_total;
   } result_type;

endpackage

FILE: src/bmq_req_if.sv
// ----------------------------------------------------------------------------
// bmq_req_if: request channel of the message queue pair
// Valid/ready channel carrying one queue operation per request.
// ----------------------------------------------------------------------------
interface bmq_req_if;
   logic                          valid;
   logic                          ready;
   logic [bmq_pkg::OP_W-1:0]      operation;
   logic [bmq_pkg::CONN_W-1:0]    dest_conn;
   logic [bmq_pkg::SEQ_W-1:0]     msg_seq_in;
   logic [bmq_pkg::HANDLE_W-1:0]  msg_handle;
   logic [bmq_pkg::DRAIN_W-1:0]   drain_max;

   modport source (output valid, operation, dest_conn, msg_seq_in, msg_handle, drain_max,
                   input ready);
   modport sink   (input valid, operation, dest_conn, msg_seq_in, msg_handle, drain_max,
                   output ready);
endinterface

FILE: src/bmq_rsp_if.sv
// ----------------------------------------------------------------------------
// bmq_rsp_if: result channel of the message queue pair
// Valid/ready channel carrying one result record per transfer.
// ----------------------------------------------------------------------------
interface bmq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic                          has_msg;
   logic [bmq_pkg::CONN_W-1:0]    out_dest;
   logic [bmq_pkg::SEQ_W-1:0]     out_seq;
   logic [bmq_pkg::HANDLE_W-1:0]  out_handle;
   logic                          last_of_run;
   logic [bmq_pkg::DROP_W-1:0]    drop_total;

   modport source (output valid, accepted, has_msg, out_dest, out_seq, out_handle,
                   last_of_run, drop_total, input ready);
   modport sink   (input valid, accepted, has_msg, out_dest, out_seq, out_handle,
                   last_of_run, drop_total, output ready);
endinterface

FILE: src/bounded_message_queue_pair.sv
// ----------------------------------------------------------------------------
// bounded_message_queue_pair: outgoing and incoming bounded message queues
// Two queues sharing one capacity register and a saturating drop counter,
// with filtered drains that close up the remaining entries in order.
// ----------------------------------------------------------------------------
// usage
//   req_if carries one request: enqueue outgoing, enqueue incoming,
//   drain outgoing (filtered by dest_conn, 0 means any) or drain incoming
//   rsp_if returns the results of that request, last_of_run on the final one
//   csr_write_en / csr_write_data set the shared queue limit (reset 16)
// timing
//   an enqueue is held as the pending result, then passed to the result register
//   a drain walks the chosen queue one entry at a time (ram read, then
//   compare and close-up), up to QUEUE_DEPTH entries
//   req_if.ready is high only while the sequencer is idle
// reset
//   both queues empty, sequence number and drop counter zero, limit 16;
//   no ram clearing pass, entries are only read below the fill counts
// stalls
//   a stalled receiver holds the result register; the walk pauses on the
//   next match until the held result has gone, so nothing is lost
// ----------------------------------------------------------------------------
module bounded_message_queue_pair #(
   parameter int QUEUE_DEPTH = bmq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   bmq_req_if.sink                       req_if,
   bmq_rsp_if.source                     rsp_if,
   input  logic                          csr_write_en,
   input  logic [bmq_pkg::LIMIT_W-1:0]   csr_write_data
);

   // one ram holds both queues: top address bit selects the queue
   localparam int IW        = $clog2(QUEUE_DEPTH);
   localparam int AW        = IW + 1;
   localparam int RAM_DEPTH = 2 ** AW;

   logic [bmq_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic                          out_vld_ff, out_vld_in;
   bmq_pkg::result_type           out_data_ff, out_data_in;

   bmq_pkg::req_type              req_data;
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [bmq_pkg::ENTRY_W-1:0]   ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [bmq_pkg::ENTRY_W-1:0]   ram_rd_data;
   logic                          push_valid;
   bmq_pkg::result_type           push_data;
   logic                          push_ready;

   // request payload gathered into one record
   assign req_data.operation  = req_if.operation;
   assign req_data.dest_conn  = req_if.dest_conn;
   assign req_data.msg_seq_in = req_if.msg_seq_in;
   assign req_data.msg_handle = req_if.msg_handle;
   assign req_data.drain_max  = req_if.drain_max;

   bmq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_data    (req_data),
      .req_ready   (req_if.ready),
      .queue_limit (limit_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_ready  (push_ready)
   );

   bmq_ram #(
      .WIDTH (bmq_pkg::ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // limit register, to be written only while idle; the block itself does not enforce this
   assign limit_in = csr_write_en ? csr_write_data : limit_ff;

   // result register: takes a new result when empty or being emptied
   assign push_ready = !out_vld_ff || rsp_if.ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      if (push_valid && push_ready) begin
         out_vld_in  = 1'b1;
         out_data_in = push_data;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= bmq_pkg::LIMIT_RESET;
         out_vld_ff <= 1'b0;
      end else begin
         limit_ff   <= limit_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.accepted    = out_data_ff.accepted;
   assign rsp_if.has_msg     = out_data_ff.has_msg;
   assign rsp_if.out_dest    = out_data_ff.out_dest;
   assign rsp_if.out_seq     = out_data_ff.out_seq;
   assign rsp_if.out_handle  = out_data_ff.out_handle;
   assign rsp_if.last_of_run = out_data_ff.last_of_run;
   assign rsp_if.drop_total  = out_data_ff.drop_total;

endmodule

FILE: src/bmq_ram.sv
// ----------------------------------------------------------------------------
// bmq_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bmq_seq.sv
// ----------------------------------------------------------------------------
// bmq_seq: sequencer of the message queue pair
// Handles enqueues and walks one queue entry at a time on a drain,
// emitting matches and closing up the kept entries in place.
// ----------------------------------------------------------------------------
module bmq_seq #(
   parameter int QUEUE_DEPTH = bmq_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int IW = $clog2(QUEUE_DEPTH),
   localparam int AW = IW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  bmq_pkg::req_type              req_data,
   output logic                          req_ready,
   input  logic [bmq_pkg::LIMIT_W-1:0]   queue_limit,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [bmq_pkg::ENTRY_W-1:0]   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [bmq_pkg::ENTRY_W-1:0]   ram_rd_data,
   output logic                          push_valid,
   output bmq_pkg::result_type           push_data,
   input  logic                          push_ready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = (CW > bmq_pkg::LIMIT_W) ? CW : bmq_pkg::LIMIT_W;

   bmq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                  cnt_ff [2];
   logic [CW-1:0]                  cnt_in [2];
   logic                           q_ff, q_in;
   logic [bmq_pkg::CONN_W-1:0]     dest_ff, dest_in;
   logic [bmq_pkg::DRAIN_W-1:0]    maxn_ff, maxn_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [IW-1:0]                  kept_ff, kept_in;
   logic [bmq_pkg::DRAIN_W-1:0]    n_ff, n_in;
   bmq_pkg::result_type            pend_ff, pend_in;
   logic                           pend_vld_ff, pend_vld_in;
   logic [bmq_pkg::SEQ_W-1:0]      seq_ff, seq_in;
   logic [bmq_pkg::DROP_W-1:0]     drop_ff, drop_in;

   logic                           req_q;
   logic                           req_enq;
   logic [CW-1:0]                  cur_cnt;
   logic                           cap_full;
   logic [bmq_pkg::DRAIN_W-1:0]    req_maxn;
   bmq_pkg::entry_type             entry;
   logic                           hit;
   logic                           take;
   logic                           stall;
   logic                           last_idx;

   // decode of the incoming request
   assign req_q   = (req_data.operation == bmq_pkg::OP_ENQ_IN) ||
                    (req_data.operation == bmq_pkg::OP_DRAIN_IN);
   assign req_enq = (req_data.operation == bmq_pkg::OP_ENQ_OUT) ||
                    (req_data.operation == bmq_pkg::OP_ENQ_IN);
   assign cur_cnt = cnt_ff[req_q];
   assign cap_full = (cur_cnt >= CW'(QUEUE_DEPTH)) ||
                     (LW'(cur_cnt) >= LW'(queue_limit));
   assign req_maxn = (req_data.drain_max > bmq_pkg::RESULT_BOUND) ?
                     bmq_pkg::RESULT_BOUND : req_data.drain_max;

   // shared compare unit for the walk
   assign entry    = bmq_pkg::entry_type'(ram_rd_data);
   assign hit      = (q_ff == bmq_pkg::Q_IN) || (dest_ff == '0) || (entry.dest == dest_ff);
   assign take     = hit && (n_ff < maxn_ff);
   assign stall    = take && pend_vld_ff && !push_ready;
   assign last_idx = ((CW'(idx_ff) + CW'(1)) == cnt_ff[q_ff]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_enq || (cur_cnt == '0)) begin
                  state_in = bmq_pkg::ST_FLUSH;
               end else begin
                  state_in = bmq_pkg::ST_READ;
               end
            end
         end
         bmq_pkg::ST_READ: begin
            state_in = bmq_pkg::ST_EVAL;
         end
         bmq_pkg::ST_EVAL: begin
            if (!stall) begin
               state_in = last_idx ? bmq_pkg::ST_FLUSH : bmq_pkg::ST_READ;
            end
         end
         bmq_pkg::ST_FLUSH: begin
            if (push_ready) begin
               state_in = bmq_pkg::ST_IDLE;
            end
         end
         default: state_in = bmq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = {q_ff, kept_ff};
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {q_ff, idx_ff};
      push_valid  = 1'b0;
      push_data   = pend_ff;
      push_data.last_of_run = 1'b0;
      push_data.drop_total  = drop_ff;
      unique case (state_ff)
         bmq_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ram_wr_en   = req_valid && req_enq && !cap_full;
            ram_wr_addr = {req_q, cur_cnt[IW-1:0]};
            ram_wr_data = {req_data.dest_conn,
                           (req_q == bmq_pkg::Q_IN) ? req_data.msg_seq_in : seq_ff,
                           req_data.msg_handle};
         end
         bmq_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
         end
         bmq_pkg::ST_EVAL: begin
            ram_wr_en  = !take;
            push_valid = take && pend_vld_ff;
         end
         bmq_pkg::ST_FLUSH: begin
            push_valid = 1'b1;
            if (!pend_vld_ff) begin
               push_data = '0;
               push_data.drop_total = drop_ff;
            end
            push_data.last_of_run = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cnt_in[0]   = cnt_ff[0];
      cnt_in[1]   = cnt_ff[1];
      q_in        = q_ff;
      dest_in     = dest_ff;
      maxn_in     = maxn_ff;
      idx_in      = idx_ff;
      kept_in     = kept_ff;
      n_in        = n_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      seq_in      = seq_ff;
      drop_in     = drop_ff;
      if ((state_ff == bmq_pkg::ST_IDLE) && req_valid) begin
         q_in    = req_q;
         dest_in = req_data.dest_conn;
         maxn_in = req_maxn;
         idx_in  = '0;
         kept_in = '0;
         n_in    = '0;
         pend_in = '0;
         if (req_enq) begin
            pend_vld_in = 1'b1;
            if (cap_full) begin
               if (drop_ff != '1) begin
                  drop_in = drop_ff + 1'b1;
               end
            end else begin
               cnt_in[req_q]    = cur_cnt + 1'b1;
               pend_in.accepted = 1'b1;
               if (req_q == bmq_pkg::Q_IN) begin
                  pend_in.out_seq = req_data.msg_seq_in;
               end else begin
                  pend_in.out_seq = seq_ff;
                  seq_in          = seq_ff + 1'b1;
               end
            end
         end else begin
            pend_vld_in = 1'b0;
         end
      end else if ((state_ff == bmq_pkg::ST_EVAL) && !stall) begin
         if (take) begin
            pend_in             = '0;
            pend_in.has_msg     = 1'b1;
            pend_in.out_dest    = entry.dest;
            pend_in.out_seq     = entry.seq;
            pend_in.out_handle  = entry.handle;
            pend_vld_in         = 1'b1;
            n_in                = n_ff + 1'b1;
         end else begin
            kept_in = kept_ff + 1'b1;
         end
         idx_in = idx_ff + 1'b1;
         if (last_idx) begin
            cnt_in[q_ff] = CW'(kept_ff) + CW'(!take);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bmq_pkg::ST_IDLE;
         cnt_ff[0]   <= '0;
         cnt_ff[1]   <= '0;
         pend_vld_ff <= 1'b0;
         seq_ff      <= '0;
         drop_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff[0]   <= cnt_in[0];
         cnt_ff[1]   <= cnt_in[1];
         pend_vld_ff <= pend_vld_in;
         seq_ff      <= seq_in;
         drop_ff     <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      dest_ff <= dest_in;
      maxn_ff <= maxn_in;
      idx_ff  <= idx_in;
      kept_ff <= kept_in;
      n_ff    <= n_in;
      pend_ff <= pend_in;
   end

endmodule

FILE: tb/bmq_queue_checker.sv
// ----------------------------------------------------------------------------
// bmq_queue_checker: result checker for the message queue pair
// Watches the request, result and limit-write ports, keeps its own copy of
// both queues, the sequence number and the drop counter, and compares each
// result with the oldest result it has worked out.
// ----------------------------------------------------------------------------
module bmq_queue_checker #(
   parameter int QUEUE_DEPTH = bmq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   bmq_req_if                            req_mon,
   bmq_rsp_if                            rsp_mon,
   input  logic                          csr_write_en,
   input  logic [bmq_pkg::LIMIT_W-1:0]   csr_write_data,
   output int                            results_outstanding,
   output int                            results_checked,
   output int                            error_count
);
   import bmq_pkg::*;

   logic [LIMIT_W-1:0] queue_limit;
   entry_type          outgoing[$];
   entry_type          incoming[$];
   logic [SEQ_W-1:0]   next_seq;
   logic [DROP_W-1:0]  drop_count;
   result_type         results_due[$];

   task automatic queue_drained(input entry_type e);
      result_type res;
      res             = '0;
      res.has_msg     = 1'b1;
      res.out_dest    = e.dest;
      res.out_seq     = e.seq;
      res.out_handle  = e.handle;
      res.drop_total  = drop_count;
      results_due.insert(results_due.size(), res);
   endtask

   task automatic predict_results(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] dest,
                                  input logic [SEQ_W-1:0] seq_in,
                                  input logic [HANDLE_W-1:0] handle,
                                  input logic [DRAIN_W-1:0] dmax);
      int         cap;
      int         lim;
      int         n;
      int         fill;
      entry_type  e;
      entry_type  kept[$];
      result_type res;
      cap = (int'(queue_limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(queue_limit);
      lim = (dmax > RESULT_BOUND) ? int'(RESULT_BOUND) : int'(dmax);
      n   = 0;
      res = '0;
      res.last_of_run = 1'b1;
      case (op)
         OP_ENQ_OUT, OP_ENQ_IN: begin
            fill = (op == OP_ENQ_OUT) ? outgoing.size() : incoming.size();
            if (fill >= cap) begin
               if (drop_count != '1) drop_count++;
            end else begin
               e.dest   = dest;
               e.handle = handle;
               if (op == OP_ENQ_OUT) begin
                  e.seq = next_seq;
                  next_seq++;
                  outgoing.insert(outgoing.size(), e);
               end else begin
                  e.seq = seq_in;
                  incoming.insert(incoming.size(), e);
               end
               res.accepted = 1'b1;
               res.out_seq  = e.seq;
            end
            res.drop_total = drop_count;
            results_due.insert(results_due.size(), res);
         end
         OP_DRAIN_OUT: begin
            foreach (outgoing[i]) begin
               if ((dest == '0 || outgoing[i].dest == dest) && n < lim) begin
                  queue_drained(outgoing[i]);
                  n++;
               end else begin
                  kept.insert(kept.size(), outgoing[i]);
               end
            end
            outgoing = kept;
         end
         default: begin
            while (n < lim && incoming.size() > 0) begin
               queue_drained(incoming[0]);
               incoming.delete(0);
               n++;
            end
         end
      endcase
      if (op == OP_DRAIN_OUT || op == OP_DRAIN_IN) begin
         if (n == 0) begin
            res.drop_total = drop_count;
            results_due.insert(results_due.size(), res);
         end else begin
            results_due[results_due.size()-1].last_of_run = 1'b1;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      result_type want;
      if (results_due.size() == 0) begin
         $display("%0t result with nothing expected: dest %h seq %h handle %h last %b",
                  $time, rsp_mon.out_dest, rsp_mon.out_seq, rsp_mon.out_handle,
                  rsp_mon.last_of_run);
         error_count++;
      end else begin
         want = results_due[0];
         results_due.delete(0);
         results_checked++;
         compare_field("accepted", 32'(want.accepted), 32'(rsp_mon.accepted));
         compare_field("has_msg", 32'(want.has_msg), 32'(rsp_mon.has_msg));
         compare_field("out_dest", 32'(want.out_dest), 32'(rsp_mon.out_dest));
         compare_field("out_seq", want.out_seq, rsp_mon.out_seq);
         compare_field("out_handle", want.out_handle, rsp_mon.out_handle);
         compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_mon.last_of_run));
         compare_field("drop_total", want.drop_total, rsp_mon.drop_total);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         queue_limit     = LIMIT_RESET;
         next_seq        = '0;
         drop_count      = '0;
         error_count     = 0;
         results_checked = 0;
         outgoing.delete();
         incoming.delete();
         results_due.delete();
      end else begin
         if (csr_write_en) queue_limit = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready)
            predict_results(req_mon.operation, req_mon.dest_conn, req_mon.msg_seq_in,
                            req_mon.msg_handle, req_mon.drain_max);
      end
      results_outstanding <= results_due.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the message queue pair
// Drives a short directed run over the corner cases, then bursts of
// enqueues followed by drains with random content, under several limits and
// idling mixes, with one long result hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
   import bmq_pkg::*;

   localparam int unsigned     WATCHDOG_LIMIT = 2000;   // cycles without any handshake
   localparam int unsigned     SETTLE_CYCLES  = 40;     // longest drain walk plus margin
   localparam int unsigned     HOLD_CYCLES    = 300;    // long result hold-off
   localparam int unsigned     PHASE_ITEMS    = 75;
   localparam logic [CONN_W-1:0] ANY_DEST     = '0;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [LIMIT_W-1:0] csr_write_data;

   bmq_req_if req_bus ();
   bmq_rsp_if rsp_bus ();

   int          results_outstanding;
   int          results_checked;
   int          error_count;

   int unsigned requests_sent   = 0;
   int unsigned send_idle_pct   = 0;
   int unsigned recv_stall_pct  = 0;
   logic        hold_results    = 1'b0;

   bounded_message_queue_pair i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   bmq_queue_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .results_outstanding (results_outstanding),
      .results_checked     (results_checked),
      .error_count         (error_count)
   );

   // 10 unit clock period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: random stalls, forced low during the hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !hold_results && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: any handshake on either channel restarts the count
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t timeout: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL bounded_message_queue_pair");
      $finish;
   end

   // one request, after a random idle gap; valid stays high when no gap follows
   task automatic send_request(input logic [OP_W-1:0] op, input logic [CONN_W-1:0] dest,
                               input logic [SEQ_W-1:0] seq, input logic [HANDLE_W-1:0] handle,
                               input logic [DRAIN_W-1:0] dmax);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.dest_conn  <= dest;
      req_bus.msg_seq_in <= seq;
      req_bus.msg_handle <= handle;
      req_bus.drain_max  <= dmax;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   // stop offering, wait for every outstanding result, then let the walk finish
   task automatic wait_until_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_until_quiet();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // mostly bursts of enqueues into one queue over a few destinations, then
   // drains of that queue; the rest is single requests with random content
   task automatic random_traffic(input int unsigned target);
      logic [CONN_W-1:0] dests [3];
      logic [OP_W-1:0]   enq_op;
      int unsigned       burst;
      while (requests_sent < target) begin
         if ($urandom_range(99) < 80) begin
            foreach (dests[k]) dests[k] = CONN_W'($urandom_range(1, 16'hFFFF));
            enq_op = $urandom_range(1) ? OP_ENQ_IN : OP_ENQ_OUT;
            burst  = $urandom_range(1, 20);
            repeat (burst)
               send_request(enq_op, dests[$urandom_range(2)], $urandom, $urandom,
                            DRAIN_W'($urandom));
            repeat ($urandom_range(1, 3)) begin
               if (enq_op == OP_ENQ_OUT)
                  send_request(OP_DRAIN_OUT,
                               ($urandom_range(3) == 0) ? ANY_DEST : dests[$urandom_range(2)],
                               $urandom, $urandom, DRAIN_W'($urandom));
               else
                  send_request(OP_DRAIN_IN, CONN_W'($urandom), $urandom, $urandom,
                               DRAIN_W'($urandom));
            end
         end else begin
            send_request(OP_W'($urandom), CONN_W'($urandom), $urandom, $urandom,
                         DRAIN_W'($urandom));
         end
      end
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input logic [LIMIT_W-1:0] limit, input bit with_hold);
      write_limit(limit);
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      // long hold-off on the result side while requests keep coming
      if (with_hold) begin
         fork
            begin
               hold_results <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_results <= 1'b0;
            end
         join_none
      end
      random_traffic(requests_sent + PHASE_ITEMS);
   endtask

   initial begin
      // every input known from the start
      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_ENQ_OUT;
      req_bus.dest_conn  <= '0;
      req_bus.msg_seq_in <= '0;
      req_bus.msg_handle <= '0;
      req_bus.drain_max  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, limit at its reset value
      // drains of empty queues give a single empty result
      send_request(OP_DRAIN_OUT, ANY_DEST, '0, '0, 5'd16);
      send_request(OP_DRAIN_IN, ANY_DEST, '0, '0, 5'd0);
      // field extremes on both queues
      send_request(OP_ENQ_OUT, 16'hFFFF, $urandom, 32'hFFFF_FFFF, 5'd0);
      send_request(OP_ENQ_OUT, 16'h0001, $urandom, 32'h0000_0000, 5'd31);
      send_request(OP_ENQ_OUT, 16'hFFFF, $urandom, 32'h1234_5678, 5'd16);
      send_request(OP_ENQ_IN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_request(OP_ENQ_IN, 16'h0000, 32'h0000_0000, 32'h0000_0000, 5'd0);
      send_request(OP_ENQ_IN, 16'h00A5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd5);
      // filtered drain taking only one, the rest close up
      send_request(OP_DRAIN_OUT, 16'hFFFF, '0, '0, 5'd1);
      // filter with no match, and a drain size of zero
      send_request(OP_DRAIN_OUT, 16'h0005, '0, '0, 5'd16);
      send_request(OP_DRAIN_OUT, ANY_DEST, '0, '0, 5'd0);
      // drain size beyond the result bound
      send_request(OP_DRAIN_OUT, 16'hFFFF, '0, '0, 5'd31);
      send_request(OP_DRAIN_IN, 16'hFFFF, '0, '0, 5'd2);
      send_request(OP_DRAIN_IN, ANY_DEST, '0, '0, 5'd31);
      send_request(OP_DRAIN_OUT, ANY_DEST, '0, '0, 5'd16);

      // limit of one: second enqueue on each side is refused
      write_limit(5'd1);
      send_request(OP_ENQ_OUT, 16'h0A0A, $urandom, $urandom, 5'd0);
      send_request(OP_ENQ_OUT, 16'h0A0A, $urandom, $urandom, 5'd0);
      send_request(OP_ENQ_IN, 16'h0B0B, $urandom, $urandom, 5'd0);
      send_request(OP_ENQ_IN, 16'h0B0B, $urandom, $urandom, 5'd0);
      send_request(OP_DRAIN_IN, ANY_DEST, '0, '0, 5'd16);
      send_request(OP_DRAIN_OUT, ANY_DEST, '0, '0, 5'd16);

      // limit of zero refuses everything
      write_limit(5'd0);
      send_request(OP_ENQ_OUT, 16'h1111, $urandom, $urandom, 5'd0);
      send_request(OP_ENQ_IN, 16'h2222, $urandom, $urandom, 5'd0);

      // random part: limit above depth first, with the long hold-off
      run_phase(0, 0, 5'd31, 1'b1);
      run_phase(68, 0, 5'd5, 1'b0);
      run_phase(0, 68, 5'd16, 1'b0);
      run_phase(26, 26, 5'd10, 1'b0);

      wait_until_quiet();

      $display("covered %0d requests: directed corner cases, then bursts and drains",
               requests_sent);
      $display("under limits 0 to 31 and four idling mixes; %0d results checked",
               results_checked);
      if (error_count == 0 && results_outstanding == 0)
         $display("PASS bounded_message_queue_pair");
      else
         $display("FAIL bounded_message_queue_pair");
      $finish;
   end

endmodule

FILE: files.f
src/bmq_pkg.sv
src/bmq_req_if.sv
src/bmq_rsp_if.sv
src/bmq_ram.sv
src/bmq_seq.sv
src/bounded_message_queue_pair.sv
tb/bmq_queue_checker.sv
tb/tb_top.sv
